// ===== rtl/murmur3_32_hash_stream_macros.svh =====
// Assertion macros shared by the murmur3 hash stream modules.
`ifndef MURMUR3_32_HASH_STREAM_MACROS_SVH
`define MURMUR3_32_HASH_STREAM_MACROS_SVH

`ifndef SYNTHESIS
// Check a clocked property, idle during reset.
`define M3H_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("m3h assertion failed");
// Check that a condition never holds at a clock edge.
`define M3H_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("m3h forbidden condition seen");
`else
`define M3H_ASSERT(lbl, prop)
`define M3H_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/m3h_pkg.sv =====
// Constants, types and helper functions for the murmur3 hash stream.
package m3h_pkg;

  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] ROUND_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;

  localparam int unsigned MAX_BYTES = 4;

  // Queue between the mixing front and the hash back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 3);

  typedef logic [2:0] byte_cnt_t;

  // One mixed word on its way to the hash recurrence.
  typedef struct packed {
    logic [31:0] k;
    byte_cnt_t   cnt;
    logic        last;
  } m3h_item_t;

  // Clamp the byte count to a full word.
  function automatic byte_cnt_t sat_count(input byte_cnt_t cnt);
    if (cnt > byte_cnt_t'(MAX_BYTES)) begin
      return byte_cnt_t'(MAX_BYTES);
    end
    return cnt;
  endfunction

  // Zero the bytes beyond the valid count.
  function automatic logic [31:0] mask_bytes(input logic [31:0] word, input byte_cnt_t cnt);
    logic [31:0] m;
    unique case (cnt)
      3'd0:    m = 32'h00000000;
      3'd1:    m = 32'h000000ff;
      3'd2:    m = 32'h0000ffff;
      3'd3:    m = 32'h00ffffff;
      default: m = 32'hffffffff;
    endcase
    return word & m;
  endfunction

endpackage

// ===== rtl/murmur3_32_hash_stream.sv =====
// Top level of the streaming MurmurHash3 x86_32 hasher.
//
// Usage: a message streams in as little-endian 32-bit words on the in_
// channel, one transfer per word, first byte in bits 7:0. in_byte_count
// gives the valid bytes (0..4, values above 4 count as 4); the word that
// carries in_last = 1 ends the message and may hold 1..4 bytes, or zero
// bytes for an empty message. Each message yields one transfer on the
// out_ channel with the finalized hash in out_hash_value.
// The seed register is written on the cfg_ channel (always ready); it is
// sampled by the first word of each message, so write it between messages.
// Throughput: one word per cycle while the message runs and in_ready stays
// high, the mixing multiplies sitting in a two-stage front pipe ahead of the
// hash recurrence. The last word takes the back end through the recurrence,
// then the fmix32 finalizer's two multiplies and the result register load;
// the back end takes no new word until the result is loaded.
// A four-entry queue decouples front and back; in_ready drops when queued
// plus in-flight words would overrun it. When out_ready is held low the
// result register holds, the back end waits in the finalizer, the queue
// fills and in_ready falls. Reset clears seed to zero, empties the queue
// and starts a new message with the next word.
module murmur3_32_hash_stream
  import m3h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed
);

  logic [31:0]     seed_r;
  logic            push, pop, q_valid;
  m3h_item_t       push_item, q_item;
  logic [Q_CW-1:0] q_level;

  // Seed register: take every transfer on the config channel.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid) begin
      seed_r <= cfg_seed;
    end
  end

  // Front: accept, clamp and mask, mix each word independently.
  m3h_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .q_level       (q_level),
    .push          (push),
    .push_item     (push_item)
  );

  // Queue: hold mixed words until the back end takes them.
  m3h_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_level   (q_level)
  );

  // Back: fold words into the running hash, finalize on the last word.
  m3h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule

// ===== rtl/m3h_front.sv =====
// Front end: accept words, mask tail bytes and run the two-multiply word mix.
`include "murmur3_32_hash_stream_macros.svh"

module m3h_front
  import m3h_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_byte_count,
  input  logic                in_last,
  input  logic [Q_CW-1:0]     q_level,
  output logic                push,
  output m3h_item_t           push_item
);

  logic            s1_v_r, s1_v_nxt;
  logic [31:0]     s1_k_r;
  byte_cnt_t       s1_cnt_r;
  logic            s1_last_r;
  logic            s2_v_r, s2_v_nxt;
  m3h_item_t       s2_item_r;
  logic [Q_CW-1:0] inflight;
  byte_cnt_t       cnt_sat;
  logic [31:0]     k_rot;

  // Count every item already holding a queue slot, in the pipe or stored.
  assign inflight = q_level + Q_CW'(s1_v_r) + Q_CW'(s2_v_r);
  assign in_ready = (inflight < Q_CW'(Q_DEPTH));
  assign cnt_sat  = sat_count(in_byte_count);
  assign k_rot    = {s1_k_r[16:0], s1_k_r[31:17]};

  assign s1_v_nxt = in_valid && in_ready;
  assign s2_v_nxt = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r         <= mask_bytes(in_data_word, cnt_sat) * MIX_C1;
    s1_cnt_r       <= cnt_sat;
    s1_last_r      <= in_last;
    s2_item_r.k    <= k_rot * MIX_C2;
    s2_item_r.cnt  <= s1_cnt_r;
    s2_item_r.last <= s1_last_r;
  end

  assign push      = s2_v_r;
  assign push_item = s2_item_r;

  `M3H_NEVER(a_front_credit, inflight > Q_CW'(Q_DEPTH))

endmodule

// ===== rtl/m3h_queue.sv =====
// Small FIFO of mixed words between the front and the back.
`include "murmur3_32_hash_stream_macros.svh"

module m3h_queue
  import m3h_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  m3h_item_t       push_item,
  input  logic            pop,
  output logic            q_valid,
  output m3h_item_t       q_item,
  output logic [Q_CW-1:0] q_level
);

  m3h_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign q_level = count_r;

  `M3H_NEVER(a_q_overflow, push && !pop && (count_r == Q_CW'(Q_DEPTH)))
  `M3H_NEVER(a_q_underflow, pop && (count_r == '0))

endmodule

// ===== rtl/m3h_back.sv =====
// Back end: hash recurrence, byte total, fmix32 finalizer and result register.
`include "murmur3_32_hash_stream_macros.svh"

module m3h_back
  import m3h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed,
  input  logic        q_valid,
  input  m3h_item_t   q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_FIN1 = 2'd1;
  localparam logic [1:0] ST_FIN2 = 2'd2;
  localparam logic [1:0] ST_FIN3 = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic        mid_r, mid_nxt;
  logic [31:0] run_r, tot_r, fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r;
  logic [31:0] h_base, h_x, h_rot, h_new, tot_new;
  logic        out_free, load_out;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == ST_RUN) && q_valid;
  assign load_out = (state_r == ST_FIN3) && out_free;

  // Start from the seed on the first word of a message.
  assign h_base  = mid_r ? run_r : seed;
  assign h_x     = h_base ^ q_item.k;
  assign h_rot   = {h_x[18:0], h_x[31:19]};
  assign h_new   = (q_item.cnt == byte_cnt_t'(MAX_BYTES)) ?
                   ({h_rot[29:0], 2'b00} + h_rot + ROUND_ADD) : h_x;
  assign tot_new = (mid_r ? tot_r : 32'd0) + 32'(q_item.cnt);

  always_comb begin
    state_nxt = state_r;
    mid_nxt   = mid_r;
    fin_nxt   = fin_r;
    unique case (state_r)
      ST_RUN: begin
        if (pop) begin
          if (q_item.last) begin
            fin_nxt   = h_new ^ tot_new;
            mid_nxt   = 1'b0;
            state_nxt = ST_FIN1;
          end else begin
            mid_nxt = 1'b1;
          end
        end
      end
      ST_FIN1: begin
        fin_nxt   = (fin_r ^ {16'd0, fin_r[31:16]}) * FIN_C1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        fin_nxt   = (fin_r ^ {13'd0, fin_r[31:13]}) * FIN_C2;
        state_nxt = ST_FIN3;
      end
      ST_FIN3: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    if (pop && !q_item.last) begin
      run_r <= h_new;
      tot_r <= tot_new;
    end
    if (load_out) begin
      out_hash_r <= fin_r ^ {16'd0, fin_r[31:16]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  `M3H_ASSERT(a_back_last_finalizes, (pop && q_item.last) |=> (state_r == ST_FIN1))
  `M3H_ASSERT(a_back_load_sets_valid, load_out |=> out_valid_r)
  `M3H_NEVER(a_back_mid_in_fin, (state_r != ST_RUN) && mid_r)

endmodule

// ===== dv/murmur3_32_hash_stream_test.sv =====
// Self-checking testbench for the streaming MurmurHash3 x86_32 hasher.
`timescale 1ns / 1ps

module murmur3_32_hash_stream_test;

  // Murmur3 x86_32 mixing and finalizer constants.
  localparam bit [31:0] K_MUL1   = 32'hcc9e2d51;
  localparam bit [31:0] K_MUL2   = 32'h1b873593;
  localparam bit [31:0] H_ADD    = 32'he6546b64;
  localparam bit [31:0] F_MUL1   = 32'h85ebca6b;
  localparam bit [31:0] F_MUL2   = 32'hc2b2ae35;
  localparam int        FULL_CNT = 4;

  // Cycles to let the front pipe and finalizer drain.
  localparam int SETTLE_CYCLES = 12;
  // Consecutive cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;
  // Idle chance per cycle, in percent, on either side.
  localparam int IDLE_PCT      = 8;

  // Running Murmur3 state plus the queue of hashes still owed by the block.
  class murmur_ledger;
    bit [31:0]   seed_reg;
    bit [31:0]   run_hash;
    bit [31:0]   run_total;
    bit          in_msg;
    bit [31:0]   pending_hashes[$];
    int          mismatches;

    function void load_seed(bit [31:0] value);
      seed_reg = value;
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int r);
      return (v << r) | (v >> (32 - r));
    endfunction

    function bit [31:0] scramble(bit [31:0] k);
      k = k * K_MUL1;
      k = rotl(k, 15);
      k = k * K_MUL2;
      return k;
    endfunction

    // Fold one accepted word into the message; queue the hash on the last one.
    function void note_word(bit [31:0] word, bit [2:0] cnt, bit last_flag);
      bit [31:0]   h;
      bit [31:0]   total;
      int unsigned n;
      h     = in_msg ? run_hash : seed_reg;
      total = in_msg ? run_total : 32'd0;
      n     = (cnt > FULL_CNT) ? FULL_CNT : cnt;
      if (n == FULL_CNT) begin
        h ^= scramble(word);
        h  = rotl(h, 13);
        h  = h * 5 + H_ADD;
      end else if (n > 0) begin
        // Tail word: zero the unused lanes, XOR in with no round.
        h ^= scramble(word & (32'hffffffff >> (8 * (FULL_CNT - n))));
      end
      total += n;
      if (last_flag) begin
        h ^= total;
        h ^= h >> 16;
        h  = h * F_MUL1;
        h ^= h >> 13;
        h  = h * F_MUL2;
        h ^= h >> 16;
        pending_hashes.push_back(h);
        run_hash  = '0;
        run_total = '0;
        in_msg    = 1'b0;
      end else begin
        run_hash  = h;
        run_total = total;
        in_msg    = 1'b1;
      end
    endfunction

    function void check_hash(logic [31:0] got);
      bit [31:0] want;
      if (pending_hashes.size() == 0) begin
        $error("hash_value: unexpected result %h with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = pending_hashes.pop_front();
      if (got !== want) begin
        $error("hash_value mismatch: expected %h, actual %h", want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_hashes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_hash_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed;

  murmur_ledger ledger;
  bit           calm;         // suppress idling on both sides
  int           words_sent;
  int           msgs_sent;
  int           hashes_seen;
  int           seeds_used;

  murmur3_32_hash_stream u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_seed       (cfg_seed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check every transfer, then pick the next ready with
  // random stalls unless the calm stretch is on.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        ledger.check_hash(out_hash_value);
        hashes_seen++;
      end
      out_ready <= rst_n && (calm || ($urandom_range(99) >= IDLE_PCT));
    end
  end

  // Watchdog: any transfer on any channel resets the quiet count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("murmur3_32_hash_stream_test: errors");
    $finish;
  end

  // Present one word and hold it until the transfer. Valid stays high on
  // return so a back-to-back word needs no extra edge.
  task automatic send_word(bit [31:0] word, bit [2:0] cnt, bit last_flag);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= word;
    in_byte_count <= cnt;
    in_last       <= last_flag;
    do @(posedge clk); while (!in_ready);
    ledger.note_word(word, cnt, last_flag);
    words_sent++;
    if (last_flag) begin
      msgs_sent++;
    end
  endtask

  // Drop valid, wait for every owed hash, then let the pipe go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(bit [31:0] value);
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do @(posedge clk); while (!cfg_ready);
    ledger.load_seed(value);
    seeds_used++;
    cfg_valid <= 1'b0;
  endtask

  // Well-formed messages with random content, laced with odd byte counts
  // mid-message and oversized counts on the tail.
  task automatic run_messages(int target);
    int start;
    int n_full;
    start = words_sent;
    while (words_sent - start < target) begin
      n_full = ($urandom_range(99) < 10) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      repeat (n_full) begin
        if ($urandom_range(99) < 10) begin
          send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        end else begin
          send_word($urandom, 3'(FULL_CNT), 1'b0);
        end
      end
      if ($urandom_range(99) < 10) begin
        send_word($urandom, 3'($urandom_range(5, 7)), 1'b1);
      end else begin
        send_word($urandom, 3'($urandom_range(0, FULL_CNT)), 1'b1);
      end
    end
  endtask

  initial begin
    bit [31:0] phase_seeds[4];
    ledger        = new();
    calm          = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_word  <= '0;
    in_byte_count <= '0;
    in_last       <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_seed      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message on the reset seed.
    send_word(32'h0, 3'd0, 1'b1);
    drain();

    write_seed(32'hffffffff);
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);          // single full word as the last
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'hdeadbeef, 3'd3, 1'b1);
    send_word(32'ha5a5a5a5, 3'd2, 1'b1);
    send_word(32'h5a5a5a5a, 3'd1, 1'b1);
    // Counts above four clamp to a full word.
    send_word(32'h12345678, 3'd7, 1'b0);
    send_word(32'h87654321, 3'd5, 1'b0);
    send_word(32'hffffffff, 3'd6, 1'b1);
    // Short and empty words in the middle of a message.
    send_word(32'hcafef00d, 3'd2, 1'b0);
    send_word(32'h00000000, 3'd0, 1'b0);
    send_word(32'h13579bdf, 3'd4, 1'b0);
    send_word(32'hffffff00, 3'd1, 1'b1);
    // Seed change mid-message applies only to the next message.
    send_word(32'h0f0f0f0f, 3'd4, 1'b0);
    drain();
    write_seed(32'h80000000);
    send_word(32'hf0f0f0f0, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd0, 1'b1);
    drain();

    phase_seeds[0] = $urandom;
    phase_seeds[1] = 32'h00000000;
    phase_seeds[2] = 32'hffffffff;
    phase_seeds[3] = $urandom;
    for (int p = 0; p < 4; p++) begin
      write_seed(phase_seeds[p]);
      calm = (p == 2);
      run_messages(100);
      // Hold the sender until every hash of the phase is back.
      drain();
    end
    calm = 1'b0;

    $display("covered %0d words in %0d messages, %0d hashes compared, %0d seed values",
             words_sent, msgs_sent, hashes_seen, seeds_used);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("murmur3_32_hash_stream_test: clean");
    end else begin
      $display("murmur3_32_hash_stream_test: errors");
    end
    $finish;
  end

endmodule
